// ===== src/cci_pkg.sv =====
// Shared constants for the circle-circle intersection pipeline.
`default_nettype none

package cci_pkg;

    // Width of the multiplier operand slice handled in one pipeline stage.
    localparam int MUL_CHUNK = 16;

endpackage

`default_nettype wire

// ===== src/circle_circle_intersection_top.sv =====
// Top level of the pipelined circle-circle intersection block.
//
// Usage: present two circles on the i_first_* and i_second_* ports and raise
// start. A word is accepted at every rising edge where start is high and busy
// is low; busy is always low, so a new word can enter on every cycle.
// Each accepted word yields exactly one result word, shown for one cycle with
// o_valid high: o_found, and the two points o_point_a_* and o_point_b_*.
// When the circles do not meet, or are concentric, o_found is low and all
// points read zero.
// A word passes the input and offset registers, the first multiplier group,
// the chord register, the second group, the radicand register, the square
// root (2*W stages), the third group, the numerator register, the rounding
// dividers (W stages) and the output register. W is COORD_WIDTH and NA, NB,
// NC are the stage counts of the three multiplier groups (operand widths
// W+1, 2*W+4 and 2*W, sliced 16 bits per stage). Throughput is one word per
// cycle; results leave in acceptance order. Reset clears the valid pipeline,
// so words in flight are dropped and results come only from later words.
// The receiver cannot stall; each result must be taken in its cycle.
`default_nettype none

module circle_circle_intersection_top import cci_pkg::*; #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] i_first_x,
    input  logic signed [COORD_WIDTH-1:0] i_first_y,
    input  logic        [COORD_WIDTH-2:0] i_first_radius,
    input  logic signed [COORD_WIDTH-1:0] i_second_x,
    input  logic signed [COORD_WIDTH-1:0] i_second_y,
    input  logic        [COORD_WIDTH-2:0] i_second_radius,
    output logic                          o_valid,
    output logic                          o_found,
    output logic signed [COORD_WIDTH-1:0] o_point_a_x,
    output logic signed [COORD_WIDTH-1:0] o_point_a_y,
    output logic signed [COORD_WIDTH-1:0] o_point_b_x,
    output logic signed [COORD_WIDTH-1:0] o_point_b_y
);

    localparam int W    = COORD_WIDTH;
    localparam int DXW  = W + 1;
    localparam int SQW  = 2 * DXW;
    localparam int D2W  = 2 * W + 3;
    localparam int MW   = 2 * W + 5;
    localparam int AMW  = 2 * W + 4;
    localparam int PPW  = SQW + AMW;
    localparam int MMW  = 2 * AMW;
    localparam int XMW  = DXW + AMW;
    localparam int KW   = 4 * W;
    localparam int SW   = 2 * W;
    localparam int XSW  = DXW + SW;
    localparam int NUMW = 3 * W + 7;
    localparam int NW   = 3 * W + 8;
    localparam int DENW = 2 * W + 4;
    localparam int QW   = W;
    localparam int OW   = W + 2;
    localparam int NA   = (DXW + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int NB   = (AMW + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int NC   = (SW + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int LAT  = 6 + NA + NB + SW + NC + QW;

    localparam int SAW = 2 * W + 2 + 2 * DXW;
    localparam int SBW = SAW + D2W + 2;
    localparam int SSW = SBW + 2 * XMW;
    localparam int SCW = 2 * W + 2 + D2W + 2 + 2 * XMW;
    localparam int SDW = 2 * W + 1 + 4;

    // Saturate a widened coordinate to the signed output range.
    function automatic logic signed [W-1:0] sat_coord(input logic signed [OW-1:0] v);
        logic [OW-W:0] top;
        logic signed [W-1:0] res;
        top = v[OW-1:W-1];
        if (top == '0 || top == '1) begin
            res = v[W-1:0];
        end else if (v[OW-1]) begin
            res = {1'b1, {(W-1){1'b0}}};
        end else begin
            res = {1'b0, {(W-1){1'b1}}};
        end
        return res;
    endfunction

    // Valid pipeline: one bit per stage, aligned with the data.
    logic [LAT-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], start & ~busy};
        end
    end

    assign busy = 1'b0;

    // Input registers.
    logic signed [W-1:0] r1_x1, r1_y1, r1_x2, r1_y2;
    logic        [W-2:0] r1_r1, r1_r2;

    always_ff @(posedge i_clk) begin
        r1_x1 <= i_first_x;
        r1_y1 <= i_first_y;
        r1_r1 <= i_first_radius;
        r1_x2 <= i_second_x;
        r1_y2 <= i_second_y;
        r1_r2 <= i_second_radius;
    end

    // Center offsets, their magnitudes, and radius sum and difference.
    logic signed [DXW-1:0] dx, dy;
    logic [DXW-1:0] r2_adx, r2_ady;
    logic           r2_sx, r2_sy;
    logic [W-1:0]   r2_sum;
    logic [W-2:0]   r2_dif, r2_r1, r2_r2;
    logic signed [W-1:0] r2_x1, r2_y1;

    assign dx = $signed({r1_x2[W-1], r1_x2}) - $signed({r1_x1[W-1], r1_x1});
    assign dy = $signed({r1_y2[W-1], r1_y2}) - $signed({r1_y1[W-1], r1_y1});

    always_ff @(posedge i_clk) begin
        r2_adx <= dx[DXW-1] ? DXW'(-dx) : DXW'(dx);
        r2_ady <= dy[DXW-1] ? DXW'(-dy) : DXW'(dy);
        r2_sx  <= dx[DXW-1];
        r2_sy  <= dy[DXW-1];
        r2_sum <= W'(r1_r1) + W'(r1_r2);
        r2_dif <= (r1_r1 > r1_r2) ? (r1_r1 - r1_r2) : (r1_r2 - r1_r1);
        r2_r1  <= r1_r1;
        r2_r2  <= r1_r2;
        r2_x1  <= r1_x1;
        r2_y1  <= r1_y1;
    end

    // First multiplier group: squares of offsets, radii, and radius sum and difference.
    logic [SQW-1:0] dxsq, dysq, r1sq, r2sq, sumsq, difsq;

    cci_mul #(.AW(DXW), .BW(DXW)) u_mul_dxsq (
        .i_clk(i_clk), .i_a(r2_adx), .i_b(r2_adx), .o_p(dxsq));
    cci_mul #(.AW(DXW), .BW(DXW)) u_mul_dysq (
        .i_clk(i_clk), .i_a(r2_ady), .i_b(r2_ady), .o_p(dysq));
    cci_mul #(.AW(DXW), .BW(DXW)) u_mul_r1sq (
        .i_clk(i_clk), .i_a(DXW'(r2_r1)), .i_b(DXW'(r2_r1)), .o_p(r1sq));
    cci_mul #(.AW(DXW), .BW(DXW)) u_mul_r2sq (
        .i_clk(i_clk), .i_a(DXW'(r2_r2)), .i_b(DXW'(r2_r2)), .o_p(r2sq));
    cci_mul #(.AW(DXW), .BW(DXW)) u_mul_sumsq (
        .i_clk(i_clk), .i_a(DXW'(r2_sum)), .i_b(DXW'(r2_sum)), .o_p(sumsq));
    cci_mul #(.AW(DXW), .BW(DXW)) u_mul_difsq (
        .i_clk(i_clk), .i_a(DXW'(r2_dif)), .i_b(DXW'(r2_dif)), .o_p(difsq));

    logic [SAW-1:0] sa_q;
    logic signed [W-1:0] a_x1, a_y1;
    logic a_sx, a_sy;
    logic [DXW-1:0] a_adx, a_ady;

    cci_delay #(.WIDTH(SAW), .DEPTH(NA)) u_dly_a (
        .i_clk(i_clk),
        .i_d({r2_x1, r2_y1, r2_sx, r2_sy, r2_adx, r2_ady}),
        .o_q(sa_q));

    assign {a_x1, a_y1, a_sx, a_sy, a_adx, a_ady} = sa_q;

    // Squared distance, meeting test and chord term M.
    logic [D2W-1:0] d2;
    logic signed [MW-1:0] mv;
    logic [D2W-1:0] r3_d2;
    logic           r3_ok, r3_sm;
    logic [AMW-1:0] r3_am;
    logic [SQW-1:0] r3_r1s;
    logic [SAW-1:0] r3_side;

    assign d2 = D2W'(dxsq) + D2W'(dysq);
    assign mv = $signed(MW'(d2)) + $signed(MW'(r1sq)) - $signed(MW'(r2sq));

    always_ff @(posedge i_clk) begin
        r3_d2   <= d2;
        r3_ok   <= (d2 != '0) && (d2 >= D2W'(difsq)) && (d2 <= D2W'(sumsq));
        r3_sm   <= mv[MW-1];
        r3_am   <= mv[MW-1] ? AMW'(-mv) : AMW'(mv);
        r3_r1s  <= r1sq;
        r3_side <= {a_x1, a_y1, a_sx, a_sy, a_adx, a_ady};
    end

    // Offset magnitudes sit in the low bits of the side word.
    logic [DXW-1:0] b3_adx, b3_ady;

    assign b3_adx = r3_side[2*DXW-1:DXW];
    assign b3_ady = r3_side[DXW-1:0];

    // Second multiplier group: r1^2 * D2, M^2 and the offset-scaled M terms.
    logic [PPW-1:0] pr;
    logic [MMW-1:0] mm;
    logic [XMW-1:0] xm, ym;

    cci_mul #(.AW(SQW), .BW(AMW)) u_mul_pr (
        .i_clk(i_clk), .i_a(r3_r1s), .i_b(AMW'(r3_d2)), .o_p(pr));
    cci_mul #(.AW(AMW), .BW(AMW)) u_mul_mm (
        .i_clk(i_clk), .i_a(r3_am), .i_b(r3_am), .o_p(mm));
    cci_mul #(.AW(DXW), .BW(AMW)) u_mul_xm (
        .i_clk(i_clk), .i_a(b3_adx), .i_b(r3_am), .o_p(xm));
    cci_mul #(.AW(DXW), .BW(AMW)) u_mul_ym (
        .i_clk(i_clk), .i_a(b3_ady), .i_b(r3_am), .o_p(ym));

    logic [SBW-1:0] sb_q;

    cci_delay #(.WIDTH(SBW), .DEPTH(NB)) u_dly_b (
        .i_clk(i_clk),
        .i_d({r3_side, r3_d2, r3_ok, r3_sm}),
        .o_q(sb_q));

    // Radicand 4*r1^2*D2 - M^2, clamped at zero.
    logic signed [MMW:0] kd;
    logic [KW-1:0]  r4_k;
    logic [SSW-1:0] r4_side;

    assign kd = $signed((MMW+1)'({pr, 2'b00})) - $signed((MMW+1)'(mm));

    always_ff @(posedge i_clk) begin
        r4_k    <= kd[MMW] ? '0 : kd[KW-1:0];
        r4_side <= {sb_q, xm, ym};
    end

    // Half-chord root.
    logic [SW-1:0]  sroot;
    logic [SSW-1:0] ss_q;

    cci_sqrt #(.KW(KW)) u_sqrt (
        .i_clk(i_clk), .i_k(r4_k), .o_root(sroot));

    cci_delay #(.WIDTH(SSW), .DEPTH(SW)) u_dly_s (
        .i_clk(i_clk), .i_d(r4_side), .o_q(ss_q));

    logic signed [W-1:0] s_x1, s_y1;
    logic s_sx, s_sy, s_ok, s_sm;
    logic [DXW-1:0] s_adx, s_ady;
    logic [D2W-1:0] s_d2;
    logic [XMW-1:0] s_xm, s_ym;

    assign {s_x1, s_y1, s_sx, s_sy, s_adx, s_ady, s_d2, s_ok, s_sm, s_xm, s_ym} = ss_q;

    // Third multiplier group: offsets times the root.
    logic [XSW-1:0] xs, ys;

    cci_mul #(.AW(DXW), .BW(SW)) u_mul_xs (
        .i_clk(i_clk), .i_a(s_adx), .i_b(sroot), .o_p(xs));
    cci_mul #(.AW(DXW), .BW(SW)) u_mul_ys (
        .i_clk(i_clk), .i_a(s_ady), .i_b(sroot), .o_p(ys));

    logic [SCW-1:0] sc_q;

    cci_delay #(.WIDTH(SCW), .DEPTH(NC)) u_dly_c (
        .i_clk(i_clk),
        .i_d({s_x1, s_y1, s_sx, s_sy, s_d2, s_ok, s_sm, s_xm, s_ym}),
        .o_q(sc_q));

    logic signed [W-1:0] c_x1, c_y1;
    logic c_sx, c_sy, c_ok, c_sm;
    logic [D2W-1:0] c_d2;
    logic [XMW-1:0] c_xm, c_ym;

    assign {c_x1, c_y1, c_sx, c_sy, c_d2, c_ok, c_sm, c_xm, c_ym} = sc_q;

    // Signed numerators of the four coordinates, then magnitude plus half divisor.
    logic signed [NUMW-1:0] tm_x, tm_y, ts_x, ts_y;
    logic signed [NUMW-1:0] numv [4];
    logic [NW-1:0]   r6_num [4];
    logic [3:0]      r6_neg;
    logic [DENW-1:0] r6_den;
    logic signed [W-1:0] r6_x1, r6_y1;
    logic            r6_ok;

    assign tm_x = (c_sx ^ c_sm) ? -$signed(NUMW'(c_xm)) : $signed(NUMW'(c_xm));
    assign tm_y = (c_sy ^ c_sm) ? -$signed(NUMW'(c_ym)) : $signed(NUMW'(c_ym));
    assign ts_x = c_sx ? -$signed(NUMW'(xs)) : $signed(NUMW'(xs));
    assign ts_y = c_sy ? -$signed(NUMW'(ys)) : $signed(NUMW'(ys));

    assign numv[0] = tm_x + ts_y;
    assign numv[1] = tm_y - ts_x;
    assign numv[2] = tm_x - ts_y;
    assign numv[3] = tm_y + ts_x;

    for (genvar l = 0; l < 4; l++) begin : g_num
        always_ff @(posedge i_clk) begin
            r6_neg[l] <= numv[l][NUMW-1];
            r6_num[l] <= (numv[l][NUMW-1] ? NW'(-numv[l]) : NW'(numv[l])) + NW'(c_d2);
        end
    end

    always_ff @(posedge i_clk) begin
        r6_den <= DENW'({c_d2, 1'b0});
        r6_x1  <= c_x1;
        r6_y1  <= c_y1;
        r6_ok  <= c_ok;
    end

    // Rounded division by 2*D2 on four lanes.
    logic [QW-1:0]  quo [4];
    logic [SDW-1:0] sd_q;

    for (genvar l = 0; l < 4; l++) begin : g_div
        cci_div #(.NW(NW), .DW(DENW), .QW(QW)) u_div (
            .i_clk(i_clk), .i_num(r6_num[l]), .i_den(r6_den), .o_quo(quo[l]));
    end

    cci_delay #(.WIDTH(SDW), .DEPTH(QW)) u_dly_d (
        .i_clk(i_clk),
        .i_d({r6_x1, r6_y1, r6_ok, r6_neg}),
        .o_q(sd_q));

    logic signed [W-1:0] d_x1, d_y1;
    logic d_ok;
    logic [3:0] d_neg;

    assign {d_x1, d_y1, d_ok, d_neg} = sd_q;

    // Add the first center, saturate, and zero the points on a miss.
    logic signed [OW-1:0] coord [4];
    logic signed [W-1:0]  r_pt  [4];
    logic                 r_found;

    for (genvar l = 0; l < 4; l++) begin : g_out
        logic signed [OW-1:0] base;
        logic signed [OW-1:0] ofs;
        assign base = (l % 2 == 0) ? OW'(d_x1) : OW'(d_y1);
        assign ofs  = d_neg[l] ? -$signed(OW'(quo[l])) : $signed(OW'(quo[l]));
        assign coord[l] = base + ofs;
        always_ff @(posedge i_clk) begin
            r_pt[l] <= d_ok ? sat_coord(coord[l]) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else begin
            r_found <= r_vld[LAT-2] & d_ok;
        end
    end

    assign o_valid     = r_vld[LAT-1];
    assign o_found     = r_found;
    assign o_point_a_x = r_pt[0];
    assign o_point_a_y = r_pt[1];
    assign o_point_b_x = r_pt[2];
    assign o_point_b_y = r_pt[3];

    // A result word only appears a full latency after an accepted word.
    a_valid_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LAT))
        else $error("result word without a matching accepted word");

    // The found flag is never raised outside a result cycle.
    a_found_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_found |-> o_valid)
        else $error("found flag raised outside a result cycle");

    // A miss reports all points as zero.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |->
        (o_point_a_x == '0 && o_point_a_y == '0 && o_point_b_x == '0 && o_point_b_y == '0))
        else $error("nonzero point reported for non-meeting circles");

endmodule

`default_nettype wire

// ===== src/cci_delay.sv =====
// Fixed-depth shift register that carries side data alongside a pipeline.
`default_nettype none

module cci_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);

    logic [WIDTH-1:0] r_tap [DEPTH];

    // Every tap moves one place each cycle.
    always_ff @(posedge i_clk) begin
        r_tap[0] <= i_d;
        for (int i = 1; i < DEPTH; i++) begin
            r_tap[i] <= r_tap[i-1];
        end
    end

    assign o_q = r_tap[DEPTH-1];

endmodule

`default_nettype wire

// ===== src/cci_mul.sv =====
// Pipelined unsigned multiplier that consumes one slice of the second operand per stage.
`default_nettype none

module cci_mul import cci_pkg::*; #(
    parameter int AW = 8,
    parameter int BW = 8
) (
    input  logic            i_clk,
    input  logic [AW-1:0]   i_a,
    input  logic [BW-1:0]   i_b,
    output logic [AW+BW-1:0] o_p
);

    localparam int NS = (BW + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int BP = NS * MUL_CHUNK;
    localparam int PW = AW + BP;
    localparam int CW = AW + MUL_CHUNK;

    logic [BP-1:0] b_pad;
    logic [AW-1:0] r_a   [NS];
    logic [BP-1:0] r_b   [NS];
    logic [PW-1:0] r_acc [NS];

    assign b_pad = BP'(i_b);

    // Each stage adds one shifted partial product to the running sum.
    for (genvar g = 0; g < NS; g++) begin : g_stage
        logic [CW-1:0] pp;
        if (g == 0) begin : g_head
            assign pp = i_a * b_pad[MUL_CHUNK-1:0];
            always_ff @(posedge i_clk) begin
                r_a[g]   <= i_a;
                r_b[g]   <= b_pad;
                r_acc[g] <= PW'(pp);
            end
        end else begin : g_body
            assign pp = r_a[g-1] * r_b[g-1][g*MUL_CHUNK +: MUL_CHUNK];
            always_ff @(posedge i_clk) begin
                r_a[g]   <= r_a[g-1];
                r_b[g]   <= r_b[g-1];
                r_acc[g] <= r_acc[g-1] + (PW'(pp) << (g*MUL_CHUNK));
            end
        end
    end

    assign o_p = r_acc[NS-1][AW+BW-1:0];

endmodule

`default_nettype wire

// ===== src/cci_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
`default_nettype none

module cci_sqrt #(
    parameter int KW = 8
) (
    input  logic            i_clk,
    input  logic [KW-1:0]   i_k,
    output logic [KW/2-1:0] o_root
);

    localparam int SW  = KW / 2;
    localparam int RMW = SW + 2;
    localparam int CUW = SW + 4;

    logic [RMW-1:0] r_rem  [SW];
    logic [SW-1:0]  r_root [SW];
    logic [KW-1:0]  r_rad  [SW];

    // Each stage brings in two radicand bits and decides one root bit.
    for (genvar g = 0; g < SW; g++) begin : g_step
        logic [RMW-1:0] p_rem;
        logic [SW-1:0]  p_root;
        logic [KW-1:0]  p_rad;
        logic [CUW-1:0] cur;
        logic [CUW-1:0] trial;
        if (g == 0) begin : g_head
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_rad  = i_k;
        end else begin : g_body
            assign p_rem  = r_rem[g-1];
            assign p_root = r_root[g-1];
            assign p_rad  = r_rad[g-1];
        end
        assign cur   = {p_rem, p_rad[KW-1:KW-2]};
        assign trial = CUW'({p_root, 2'b01});
        always_ff @(posedge i_clk) begin
            if (cur >= trial) begin
                r_rem[g]  <= RMW'(cur - trial);
                r_root[g] <= {p_root[SW-2:0], 1'b1};
            end else begin
                r_rem[g]  <= RMW'(cur);
                r_root[g] <= {p_root[SW-2:0], 1'b0};
            end
            r_rad[g] <= {p_rad[KW-3:0], 2'b00};
        end
    end

    assign o_root = r_root[SW-1];

endmodule

`default_nettype wire

// ===== src/cci_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module cci_div #(
    parameter int NW = 16,
    parameter int DW = 8,
    parameter int QW = 8
) (
    input  logic          i_clk,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo
);

    localparam int CUW = DW + 1;

    logic [DW-1:0] r_rem [QW];
    logic [QW-1:0] r_low [QW];
    logic [DW-1:0] r_den [QW];
    logic [QW-1:0] r_quo [QW];

    // The upper numerator part is known to be below the divisor, so only
    // the low quotient bits are developed.
    for (genvar g = 0; g < QW; g++) begin : g_step
        logic [DW-1:0]  p_rem;
        logic [QW-1:0]  p_low;
        logic [DW-1:0]  p_den;
        logic [QW-1:0]  p_quo;
        logic [CUW-1:0] cur;
        logic           ge;
        if (g == 0) begin : g_head
            assign p_rem = i_num[QW+DW-1:QW];
            assign p_low = i_num[QW-1:0];
            assign p_den = i_den;
            assign p_quo = '0;
        end else begin : g_body
            assign p_rem = r_rem[g-1];
            assign p_low = r_low[g-1];
            assign p_den = r_den[g-1];
            assign p_quo = r_quo[g-1];
        end
        assign cur = {p_rem, p_low[QW-1]};
        assign ge  = (cur >= CUW'(p_den));
        always_ff @(posedge i_clk) begin
            r_rem[g] <= ge ? DW'(cur - CUW'(p_den)) : DW'(cur);
            r_low[g] <= {p_low[QW-2:0], 1'b0};
            r_den[g] <= p_den;
            r_quo[g] <= {p_quo[QW-2:0], ge};
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule

`default_nettype wire
